// ===== src/fbt_pkg.sv =====
// ----------------------------------------------------------------------------
// fbt_pkg: shared types and constants of the fiber bending torque unit
// Beat formats, sequencer states, divider request and response, CORDIC table.
// ----------------------------------------------------------------------------
package fbt_pkg;

	localparam int CFG_INDEX_BITS = 2;
	localparam int DIV_STEPS      = 64;

	localparam logic [CFG_INDEX_BITS-1:0] REG_YOUNG_MODULUS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_MOMENT   = 2'd1;

	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic [47:0]        TORQUE_MAX  = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0]        TORQUE_MIN  = 48'h8000_0000_0000;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic               last_hinge;
	} in_beat_t;

	typedef struct packed {
		logic signed [47:0] torque_x;
		logic signed [47:0] torque_y;
		logic signed [47:0] torque_z;
		logic [15:0]        hinge_number;
		logic               fiber_done;
	} out_beat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SHRINK_SEG,
		ST_MUL_SEG,
		ST_SQ_CHECK,
		ST_SQRT1,
		ST_SQRT2,
		ST_SHRINK_CR,
		ST_MUL_CR,
		ST_SQRT_C,
		ST_SHRINK_PAIR,
		ST_CORDIC,
		ST_DIV_K,
		ST_DIV_U,
		ST_MUL_T,
		ST_COMBINE,
		ST_OUT_H,
		ST_OUT_C,
		ST_OUT_Z,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [35:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
		logic [35:0] remainder;
	} div_rsp_t;

	// Arctangent of 2^-i in Q30 radians.
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: atan_q30 = 32'd843314857;
			5'd1: atan_q30 = 32'd497837829;
			5'd2: atan_q30 = 32'd263043837;
			5'd3: atan_q30 = 32'd133525159;
			5'd4: atan_q30 = 32'd67021687;
			5'd5: atan_q30 = 32'd33543516;
			5'd6: atan_q30 = 32'd16775851;
			5'd7: atan_q30 = 32'd8388437;
			5'd8: atan_q30 = 32'd4194283;
			5'd9: atan_q30 = 32'd2097149;
			5'd31: atan_q30 = 32'd0;
			default: atan_q30 = 32'd1 << (5'd30 - i);
		endcase
	endfunction

endpackage

// ===== src/fiber_bending_torque_unit.sv =====
// ----------------------------------------------------------------------------
// fiber_bending_torque_unit: bending torques along a fiber
// Hinge positions in, net hinge torques out, on one shared multiplier,
// a root stepper, a CORDIC stepper and a restoring divider.
// ----------------------------------------------------------------------------
//  channel  signals                        beat
//  in       in_valid / in_stall / in_data  one hinge position, last-hinge flag
//  out      out_valid / out_stall / out_data  one hinge torque, up to 3 per in beat
//  cfg      cfg_we / cfg_index / cfg_data  register write, no wait
//
// A hinge that closes a bend runs four divisions, three square roots, a
// CORDIC rotation, 28 multiplies and one-bit-a-cycle normalizing shifts.
// A zero segment ends it after the squared lengths and a zero cross
// product after the two segment roots. Reset clears the fiber state and
// sets both registers to 1.0. in_stall is high while a hinge is in work;
// out_stall only holds the output register and the emit states.
// ----------------------------------------------------------------------------
module fiber_bending_torque_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  fbt_pkg::in_beat_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output fbt_pkg::out_beat_t                  out_data,
	input  logic                                cfg_we,
	input  logic [fbt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [31:0]                         cfg_data
);

	fbt_pkg::state_t state_q, state_d;
	logic [5:0]  step_q;
	logic [31:0] young_q, area_q;
	logic signed [31:0] old_q [3];
	logic signed [31:0] new_q [3];
	logic signed [31:0] p_q [3];
	logic        last_q;
	logic [15:0] cnt_q;
	logic signed [47:0] car_q [3];
	logic signed [47:0] tq_q [3];
	logic signed [47:0] h_q [3];
	logic [32:0] m1_q [3];
	logic [32:0] m2_q [3];
	logic [2:0]  g1_q, g2_q, s1_q, s2_q;
	logic [59:0] sq1_q, sq2_q, sqc_q;
	logic signed [61:0] dot_q;
	logic signed [60:0] cr_q [3];
	logic [63:0] ei_q;
	logic [59:0] cm_q [3];
	logic [2:0]  cg_q;
	logic [5:0]  sc_q;
	logic [59:0] rad_q;
	logic [61:0] root_q, bit_q;
	logic [35:0] len_q;
	logic [29:0] cn_q;
	logic [63:0] pa_q, pb_q;
	logic        pneg_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [31:0] ang_q;
	logic [63:0] k_q;
	logic [1:0]  comp_q;
	logic [30:0] u_q;
	logic [31:0] mv_q;
	logic [63:0] ph_q;
	logic        dst_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;
	fbt_pkg::out_beat_t out_q;
	logic        out_valid_q;

	fbt_pkg::div_req_t div_req;
	fbt_pkg::div_rsp_t div_rsp;

	logic accept, can_load;
	logic [32:0] big1, big2;
	logic [59:0] bigc;
	logic [63:0] bigp;
	logic shr1, shr2, shrc, shrp, cr_zero;
	logic signed [32:0] v1s [3];
	logic signed [32:0] v2s [3];
	logic [62:0] sq_trial;
	logic sq_fits;
	logic signed [33:0] cx_sh, cy_sh, cy_abs_sh, atan_s;
	logic [63:0] ms_p;
	logic [47:0] ms_mag;

	function automatic logic signed [32:0] to_signed(input logic [31:0] m, input logic neg);
		logic signed [32:0] v;
		v = $signed({1'b0, m});
		to_signed = neg ? -v : v;
	endfunction

	function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
	                                               input logic signed [47:0] b);
		logic signed [48:0] s;
		s = {a[47], a} + {b[47], b};
		if (s[48] != s[47]) sat_add = s[48] ? $signed(fbt_pkg::TORQUE_MIN)
		                                   : $signed(fbt_pkg::TORQUE_MAX);
		else sat_add = s[47:0];
	endfunction

	function automatic logic signed [47:0] sat_neg(input logic signed [47:0] a);
		if (a == $signed(fbt_pkg::TORQUE_MIN)) sat_neg = $signed(fbt_pkg::TORQUE_MAX);
		else sat_neg = -a;
	endfunction

	assign in_stall  = state_q != fbt_pkg::ST_IDLE;
	assign accept    = in_valid && !in_stall;
	assign can_load  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		big1 = m1_q[0] | m1_q[1] | m1_q[2];
		big2 = m2_q[0] | m2_q[1] | m2_q[2];
		bigc = cm_q[0] | cm_q[1] | cm_q[2];
		bigp = pa_q | pb_q;
		shr1 = |big1[32:29];
		shr2 = |big2[32:29];
		shrc = |bigc[59:29];
		shrp = |bigp[63:29];
		cr_zero = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
		for (int i = 0; i < 3; i++) begin
			v1s[i] = to_signed(m1_q[i][31:0], g1_q[i]);
			v2s[i] = to_signed(m2_q[i][31:0], g2_q[i]);
		end
		sq_trial = {1'b0, root_q} + {1'b0, bit_q};
		sq_fits  = {3'b000, rad_q} >= sq_trial;
		cx_sh     = cx_q >>> step_q[4:0];
		cy_sh     = cy_q >>> step_q[4:0];
		cy_abs_sh = (-cy_q) >>> step_q[4:0];
		atan_s    = $signed({2'b00, fbt_pkg::atan_q30(step_q[4:0])});
		// Torque magnitude (k * m) >> 30, saturated to the largest torque.
		ms_p = {ph_q[61:0], 2'b00} + {30'd0, prod_q[63:30]};
		if (|ph_q[63:61]) ms_mag = fbt_pkg::TORQUE_MAX;
		else if (ms_p > {16'd0, fbt_pkg::TORQUE_MAX}) ms_mag = fbt_pkg::TORQUE_MAX;
		else ms_mag = ms_p[47:0];
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			fbt_pkg::ST_MUL_SEG: begin
				case (step_q)
					6'd0: begin mul_a = v1s[0]; mul_b = v1s[0]; end
					6'd1: begin mul_a = v1s[1]; mul_b = v1s[1]; end
					6'd2: begin mul_a = v1s[2]; mul_b = v1s[2]; end
					6'd3: begin mul_a = v2s[0]; mul_b = v2s[0]; end
					6'd4: begin mul_a = v2s[1]; mul_b = v2s[1]; end
					6'd5: begin mul_a = v2s[2]; mul_b = v2s[2]; end
					6'd6: begin mul_a = v1s[0]; mul_b = v2s[0]; end
					6'd7: begin mul_a = v1s[1]; mul_b = v2s[1]; end
					6'd8: begin mul_a = v1s[2]; mul_b = v2s[2]; end
					6'd9: begin mul_a = v1s[1]; mul_b = v2s[2]; end
					6'd10: begin mul_a = v1s[2]; mul_b = v2s[1]; end
					6'd11: begin mul_a = v1s[2]; mul_b = v2s[0]; end
					6'd12: begin mul_a = v1s[0]; mul_b = v2s[2]; end
					6'd13: begin mul_a = v1s[0]; mul_b = v2s[1]; end
					6'd14: begin mul_a = v1s[1]; mul_b = v2s[0]; end
					6'd15: begin
						mul_a = $signed({1'b0, young_q});
						mul_b = $signed({1'b0, area_q});
					end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			fbt_pkg::ST_MUL_CR: begin
				if (step_q < 6'd3) begin
					mul_a = $signed({1'b0, cm_q[step_q[1:0]][31:0]});
					mul_b = $signed({1'b0, cm_q[step_q[1:0]][31:0]});
				end
			end
			fbt_pkg::ST_MUL_T: begin
				case (step_q)
					6'd0: begin
						mul_a = $signed({1'b0, ang_q});
						mul_b = $signed({2'b00, u_q});
					end
					6'd2: begin
						mul_a = $signed({1'b0, k_q[63:32]});
						mul_b = $signed({1'b0, mv_q});
					end
					6'd3: begin
						mul_a = $signed({1'b0, k_q[31:0]});
						mul_b = $signed({1'b0, mv_q});
					end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		div_req.start    = (state_q == fbt_pkg::ST_DIV_K || state_q == fbt_pkg::ST_DIV_U)
		                   && !dst_q;
		div_req.dividend = ei_q;
		div_req.divisor  = len_q;
		if (state_q == fbt_pkg::ST_DIV_U) begin
			div_req.dividend = {5'd0, cm_q[comp_q][28:0], 30'd0};
			div_req.divisor  = {6'd0, cn_q};
		end
	end

	fbt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= fbt_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fbt_pkg::ST_IDLE: begin
				if (accept) begin
					if (cnt_q >= 16'd2) state_d = fbt_pkg::ST_DIFF;
					else if (in_data.last_hinge)
						state_d = (cnt_q >= 16'd1) ? fbt_pkg::ST_OUT_C : fbt_pkg::ST_OUT_Z;
					else state_d = fbt_pkg::ST_UPDATE;
				end
			end
			fbt_pkg::ST_DIFF: state_d = fbt_pkg::ST_SHRINK_SEG;
			fbt_pkg::ST_SHRINK_SEG: if (!shr1 && !shr2) state_d = fbt_pkg::ST_MUL_SEG;
			fbt_pkg::ST_MUL_SEG: if (step_q == 6'd16) state_d = fbt_pkg::ST_SQ_CHECK;
			fbt_pkg::ST_SQ_CHECK: begin
				if (sq1_q == '0 || sq2_q == '0) state_d = fbt_pkg::ST_COMBINE;
				else state_d = fbt_pkg::ST_SQRT1;
			end
			fbt_pkg::ST_SQRT1: if (bit_q == '0) state_d = fbt_pkg::ST_SQRT2;
			fbt_pkg::ST_SQRT2: begin
				if (bit_q == '0)
					state_d = cr_zero ? fbt_pkg::ST_COMBINE : fbt_pkg::ST_SHRINK_CR;
			end
			fbt_pkg::ST_SHRINK_CR: if (!shrc) state_d = fbt_pkg::ST_MUL_CR;
			fbt_pkg::ST_MUL_CR: if (step_q == 6'd4) state_d = fbt_pkg::ST_SQRT_C;
			fbt_pkg::ST_SQRT_C: if (bit_q == '0) state_d = fbt_pkg::ST_SHRINK_PAIR;
			fbt_pkg::ST_SHRINK_PAIR: if (!shrp) state_d = fbt_pkg::ST_CORDIC;
			fbt_pkg::ST_CORDIC: if (step_q == 6'd24) state_d = fbt_pkg::ST_DIV_K;
			fbt_pkg::ST_DIV_K: if (div_rsp.done) state_d = fbt_pkg::ST_DIV_U;
			fbt_pkg::ST_DIV_U: if (div_rsp.done) state_d = fbt_pkg::ST_MUL_T;
			fbt_pkg::ST_MUL_T: begin
				if (step_q == 6'd4)
					state_d = (comp_q == 2'd2) ? fbt_pkg::ST_COMBINE : fbt_pkg::ST_DIV_U;
			end
			fbt_pkg::ST_COMBINE: state_d = fbt_pkg::ST_OUT_H;
			fbt_pkg::ST_OUT_H: begin
				if (can_load) state_d = last_q ? fbt_pkg::ST_OUT_C : fbt_pkg::ST_UPDATE;
			end
			fbt_pkg::ST_OUT_C: if (can_load) state_d = fbt_pkg::ST_OUT_Z;
			fbt_pkg::ST_OUT_Z: if (can_load) state_d = fbt_pkg::ST_UPDATE;
			fbt_pkg::ST_UPDATE: state_d = fbt_pkg::ST_IDLE;
			default: state_d = fbt_pkg::ST_IDLE;
		endcase
	end

	// Control and fiber state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			young_q     <= 32'd65536;
			area_q      <= 32'd65536;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			dst_q       <= 1'b0;
			comp_q      <= '0;
			for (int i = 0; i < 3; i++) begin
				old_q[i] <= '0;
				new_q[i] <= '0;
				car_q[i] <= '0;
			end
		end else begin
			step_q <= (state_d != state_q) ? 6'd0 : step_q + 6'd1;
			if (cfg_we) begin
				case (cfg_index)
					fbt_pkg::REG_YOUNG_MODULUS: young_q <= cfg_data;
					fbt_pkg::REG_AREA_MOMENT:   area_q  <= cfg_data;
					default: ;
				endcase
			end
			if (div_req.start) dst_q <= 1'b1;
			else if (div_rsp.done) dst_q <= 1'b0;
			if (state_q == fbt_pkg::ST_DIV_K) comp_q <= '0;
			if (state_q == fbt_pkg::ST_MUL_T && step_q == 6'd4) comp_q <= comp_q + 2'd1;
			if (state_q == fbt_pkg::ST_COMBINE) begin
				for (int i = 0; i < 3; i++) car_q[i] <= sat_neg(tq_q[i]);
			end
			if ((state_q == fbt_pkg::ST_OUT_H || state_q == fbt_pkg::ST_OUT_C ||
			     state_q == fbt_pkg::ST_OUT_Z) && can_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (state_q == fbt_pkg::ST_UPDATE) begin
				if (last_q) begin
					cnt_q <= '0;
					for (int i = 0; i < 3; i++) begin
						old_q[i] <= '0;
						new_q[i] <= '0;
						car_q[i] <= '0;
					end
				end else begin
					if (cnt_q != 16'hFFFF) cnt_q <= cnt_q + 16'd1;
					for (int i = 0; i < 3; i++) begin
						old_q[i] <= new_q[i];
						new_q[i] <= p_q[i];
					end
				end
			end
		end
	end

	// Working registers of the bend computation.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			p_q[0] <= in_data.pos_x;
			p_q[1] <= in_data.pos_y;
			p_q[2] <= in_data.pos_z;
			last_q <= in_data.last_hinge;
		end
		case (state_q)
			fbt_pkg::ST_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					logic signed [32:0] d1, d2;
					d1 = {new_q[i][31], new_q[i]} - {old_q[i][31], old_q[i]};
					d2 = {p_q[i][31], p_q[i]} - {new_q[i][31], new_q[i]};
					m1_q[i] <= d1[32] ? -d1 : d1;
					m2_q[i] <= d2[32] ? -d2 : d2;
					g1_q[i] <= d1[32];
					g2_q[i] <= d2[32];
					tq_q[i] <= '0;
				end
				s1_q  <= '0;
				s2_q  <= '0;
				sq1_q <= '0;
				sq2_q <= '0;
				dot_q <= '0;
			end
			fbt_pkg::ST_SHRINK_SEG: begin
				if (shr1) begin
					for (int i = 0; i < 3; i++) m1_q[i] <= m1_q[i] >> 1;
					s1_q <= s1_q + 3'd1;
				end
				if (shr2) begin
					for (int i = 0; i < 3; i++) m2_q[i] <= m2_q[i] >> 1;
					s2_q <= s2_q + 3'd1;
				end
			end
			fbt_pkg::ST_MUL_SEG: begin
				// The product register holds the operation issued in the previous cycle.
				case (step_q)
					6'd1, 6'd2, 6'd3: sq1_q <= sq1_q + prod_q[59:0];
					6'd4, 6'd5, 6'd6: sq2_q <= sq2_q + prod_q[59:0];
					6'd7, 6'd8, 6'd9: dot_q <= dot_q + $signed(prod_q[61:0]);
					6'd10: cr_q[0] <= prod_q[60:0];
					6'd11: cr_q[0] <= cr_q[0] - $signed(prod_q[60:0]);
					6'd12: cr_q[1] <= prod_q[60:0];
					6'd13: cr_q[1] <= cr_q[1] - $signed(prod_q[60:0]);
					6'd14: cr_q[2] <= prod_q[60:0];
					6'd15: cr_q[2] <= cr_q[2] - $signed(prod_q[60:0]);
					6'd16: ei_q <= prod_q[63:0];
					default: ;
				endcase
			end
			fbt_pkg::ST_SQ_CHECK: begin
				rad_q  <= sq1_q;
				root_q <= '0;
				bit_q  <= 62'd1 << 60;
			end
			fbt_pkg::ST_SQRT1, fbt_pkg::ST_SQRT2, fbt_pkg::ST_SQRT_C: begin
				if (bit_q != '0) begin
					if (sq_fits) begin
						rad_q  <= rad_q - sq_trial[59:0];
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else if (state_q == fbt_pkg::ST_SQRT1) begin
					len_q  <= {6'd0, root_q[29:0]} << s1_q;
					rad_q  <= sq2_q;
					root_q <= '0;
					bit_q  <= 62'd1 << 60;
				end else if (state_q == fbt_pkg::ST_SQRT2) begin
					len_q <= len_q + ({6'd0, root_q[29:0]} << s2_q);
					for (int i = 0; i < 3; i++) begin
						logic signed [60:0] c;
						c = cr_q[i][60] ? -cr_q[i] : cr_q[i];
						cm_q[i] <= c[59:0];
						cg_q[i] <= cr_q[i][60];
					end
					sc_q  <= '0;
					sqc_q <= '0;
				end else begin
					logic signed [61:0] dmag;
					dmag   = dot_q[61] ? -dot_q : dot_q;
					cn_q   <= root_q[29:0];
					pa_q   <= {2'b00, dmag};
					pneg_q <= dot_q[61];
					pb_q   <= {34'd0, root_q[29:0]} << sc_q;
				end
			end
			fbt_pkg::ST_SHRINK_CR: begin
				if (shrc) begin
					for (int i = 0; i < 3; i++) cm_q[i] <= cm_q[i] >> 1;
					sc_q <= sc_q + 6'd1;
				end
			end
			fbt_pkg::ST_MUL_CR: begin
				if (step_q >= 6'd1 && step_q <= 6'd3) sqc_q <= sqc_q + prod_q[59:0];
				if (step_q == 6'd4) begin
					rad_q  <= sqc_q;
					root_q <= '0;
					bit_q  <= 62'd1 << 60;
				end
			end
			fbt_pkg::ST_SHRINK_PAIR: begin
				if (shrp) begin
					pa_q <= pa_q >> 1;
					pb_q <= pb_q >> 1;
				end else if (pneg_q && pa_q != '0) begin
					// A negative cosine starts the rotation a quarter turn on.
					cx_q <= $signed(pb_q[33:0]);
					cy_q <= $signed(pa_q[33:0]);
					cz_q <= fbt_pkg::HALF_PI_Q30;
				end else begin
					cx_q <= $signed(pa_q[33:0]);
					cy_q <= $signed(pb_q[33:0]);
					cz_q <= '0;
				end
			end
			fbt_pkg::ST_CORDIC: begin
				if (step_q < 6'd24) begin
					if (!cy_q[33]) begin
						cx_q <= cx_q + cy_sh;
						cy_q <= cy_q - cx_sh;
						cz_q <= cz_q + atan_s;
					end else begin
						cx_q <= cx_q + cy_abs_sh;
						cy_q <= cy_q + cx_sh;
						cz_q <= cz_q - atan_s;
					end
				end else if (cz_q[33]) begin
					ang_q <= '0;
				end else if (cz_q > fbt_pkg::PI_Q30) begin
					ang_q <= fbt_pkg::PI_Q30[31:0];
				end else begin
					ang_q <= cz_q[31:0];
				end
			end
			fbt_pkg::ST_DIV_K: begin
				if (div_rsp.done) begin
					if (div_rsp.quotient[63]) k_q <= '1;
					else k_q <= {div_rsp.quotient[62:0], 1'b0} +
					            64'({div_rsp.remainder, 1'b0} >= {1'b0, len_q});
				end
			end
			fbt_pkg::ST_DIV_U: begin
				if (div_rsp.done) u_q <= div_rsp.quotient[30:0];
			end
			fbt_pkg::ST_MUL_T: begin
				case (step_q)
					6'd1: mv_q <= prod_q[61:30];
					6'd3: ph_q <= prod_q[63:0];
					6'd4: tq_q[comp_q] <= cg_q[comp_q] ? -$signed(ms_mag) : $signed(ms_mag);
					default: ;
				endcase
			end
			fbt_pkg::ST_COMBINE: begin
				for (int i = 0; i < 3; i++) h_q[i] <= sat_add(car_q[i], tq_q[i]);
			end
			fbt_pkg::ST_OUT_H: begin
				if (can_load) begin
					out_q.torque_x     <= h_q[0];
					out_q.torque_y     <= h_q[1];
					out_q.torque_z     <= h_q[2];
					out_q.hinge_number <= cnt_q - 16'd2;
					out_q.fiber_done   <= 1'b0;
				end
			end
			fbt_pkg::ST_OUT_C: begin
				if (can_load) begin
					out_q.torque_x     <= car_q[0];
					out_q.torque_y     <= car_q[1];
					out_q.torque_z     <= car_q[2];
					out_q.hinge_number <= cnt_q - 16'd1;
					out_q.fiber_done   <= 1'b0;
				end
			end
			fbt_pkg::ST_OUT_Z: begin
				if (can_load) begin
					out_q.torque_x     <= '0;
					out_q.torque_y     <= '0;
					out_q.torque_z     <= '0;
					out_q.hinge_number <= cnt_q;
					out_q.fiber_done   <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_bend_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cnt_q >= 16'd2) |=> state_q == fbt_pkg::ST_DIFF)
		else $error("bend computation did not start");

	a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == fbt_pkg::ST_DIV_K || state_q == fbt_pkg::ST_DIV_U))
		else $error("divider finished outside a division step");

	a_unit_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start && state_q == fbt_pkg::ST_DIV_U |-> cn_q != '0)
		else $error("unit vector division by zero norm");

	a_stall_holds_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fbt_pkg::ST_OUT_Z && out_valid_q && out_stall)
		|=> state_q == fbt_pkg::ST_OUT_Z)
		else $error("final beat loaded over a waiting beat");

endmodule

// ===== src/fbt_div.sv =====
// ----------------------------------------------------------------------------
// fbt_div: restoring divider
// Divides a 64-bit dividend by a 36-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fbt_pkg::div_req_t req,
	output fbt_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q;
	logic [35:0] rem_q;
	logic [35:0] dvs_q;
	logic [36:0] trial;
	logic [36:0] diff;
	logic        fits;

	assign trial = {rem_q, quo_q[63]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(fbt_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], fits};
			rem_q <= fits ? diff[35:0] : trial[35:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
